>>> rtl/core/round_robin_task_scheduler_macros.svh
// ---------------------------------------------------------------------------
// Round robin task scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rrts_pkg.sv
// ---------------------------------------------------------------------------
// Round robin task scheduler package
// Table size, command and status codes, controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int MAX_TASKS = 8;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   localparam logic [2:0] CMD_SCHEDULE = 3'd0;
   localparam logic [2:0] CMD_ADD      = 3'd1;
   localparam logic [2:0] CMD_EXIT     = 3'd2;
   localparam logic [2:0] CMD_WAIT     = 3'd3;
   localparam logic [2:0] CMD_NOTIFY   = 3'd4;
   localparam logic [2:0] CMD_SLEEP    = 3'd5;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_MISMATCH = 2'd2;
   localparam logic [1:0] STS_NO_TASK  = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_step;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_sched;
      logic scan_done;
   } dp_status_type;

endpackage

>>> rtl/core/rrts_ctrl.sv
// ---------------------------------------------------------------------------
// Round robin task scheduler controller
// Sequences capture, table edit or slot scan, and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_macros.svh"

module rrts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rrts_pkg::dp_status_type sts,
   output rrts_pkg::ctrl_cmd_type  cmd_o
);
   import rrts_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_PUB  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd_o.capture   = accept;
      cmd_o.exec      = (state_ff == S_EXEC);
      cmd_o.scan_step = (state_ff == S_SCAN);
      cmd_o.publish   = (state_ff == S_PUB) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = sts.req_sched ? S_SCAN : S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_PUB;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_PUB;
            end
         end
         S_PUB: begin
            if (cmd_o.publish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd_o.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RRTS_ASSERT_NEXT(a_publish_shows, cmd_o.publish, rsp_valid_ff && state_ff == S_IDLE, "publish lost")
   `RRTS_ASSERT_NEXT(a_scan_ends, cmd_o.scan_step && sts.scan_done, state_ff == S_PUB, "scan end missed")
   `RRTS_ASSERT_NEXT(a_sched_scans, accept && sts.req_sched, state_ff == S_SCAN, "schedule not scanned")

endmodule

>>> rtl/core/rrts_dp.sv
// ---------------------------------------------------------------------------
// Round robin task scheduler datapath
// Task table, rotating scan probe, table edits and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_macros.svh"

module rrts_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rrts_pkg::ctrl_cmd_type  cmd,
   output rrts_pkg::dp_status_type sts,
   input  logic [7:0]             idle_task_id,
   input  logic [2:0]             req_command,
   input  logic [7:0]             req_task_id,
   input  logic [31:0]            req_tick_now,
   input  logic [31:0]            req_reason,
   input  logic [30:0]            req_sleep_ticks,
   input  logic [31:0]            req_check_code,
   input  logic [31:0]            req_current_check,
   output logic [7:0]             rsp_chosen_task,
   output logic                   rsp_chose_idle,
   output logic [1:0]             rsp_status,
   output logic                   rsp_reschedule_request
);
   import rrts_pkg::*;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s == SLOT_W'(MAX_TASKS - 1)) ? '0 : s + 1'b1;
      return r;
   endfunction

   logic [2:0]        cmd_ff, cmd_in;
   logic [7:0]        tid_ff, tid_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       why_ff, why_in;
   logic [30:0]       dur_ff, dur_in;
   logic              chk_ok_ff, chk_ok_in;

   logic              slot_valid_ff    [MAX_TASKS];
   logic              slot_valid_in    [MAX_TASKS];
   logic [7:0]        slot_task_ff     [MAX_TASKS];
   logic [7:0]        slot_task_in     [MAX_TASKS];
   logic              slot_sleeping_ff [MAX_TASKS];
   logic              slot_sleeping_in [MAX_TASKS];
   logic              slot_waiting_ff  [MAX_TASKS];
   logic              slot_waiting_in  [MAX_TASKS];
   logic [31:0]       slot_word_ff     [MAX_TASKS];
   logic [31:0]       slot_word_in     [MAX_TASKS];
   logic [31:0]       slot_start_ff    [MAX_TASKS];
   logic [31:0]       slot_start_in    [MAX_TASKS];

   logic [SLOT_W-1:0] rotate_ff, rotate_in;
   logic [SLOT_W-1:0] running_slot_ff, running_slot_in;
   logic              running_task_ff, running_task_in;
   logic [SLOT_W-1:0] probe_ff, probe_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   logic [7:0]        res_chosen_ff, res_chosen_in;
   logic              res_idle_ff, res_idle_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              res_resched_ff, res_resched_in;

   logic [7:0]        rsp_chosen_task_ff;
   logic              rsp_chose_idle_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_reschedule_request_ff;

   logic [31:0]       left;
   logic              woke;
   logic              runnable;
   logic              last;
   logic              free_hit;
   logic [SLOT_W-1:0] free_idx;

   assign left     = slot_word_ff[probe_ff] - (now_ff - slot_start_ff[probe_ff]);
   assign woke     = slot_sleeping_ff[probe_ff] && ((left == '0) || left[31]);
   assign runnable = slot_valid_ff[probe_ff] && (!slot_sleeping_ff[probe_ff] || woke)
                     && !slot_waiting_ff[probe_ff];
   assign last     = (cnt_ff == SLOT_W'(MAX_TASKS - 1));

   always_comb begin
      sts.req_sched = (req_command == CMD_SCHEDULE);
      sts.scan_done = runnable || last;
   end

   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int k = MAX_TASKS - 1; k >= 0; k--) begin
         if (!slot_valid_ff[k]) begin
            free_hit = 1'b1;
            free_idx = SLOT_W'(k);
         end
      end
   end

   always_comb begin
      cmd_in    = cmd_ff;
      tid_in    = tid_ff;
      now_in    = now_ff;
      why_in    = why_ff;
      dur_in    = dur_ff;
      chk_ok_in = chk_ok_ff;
      if (cmd.capture) begin
         cmd_in    = req_command;
         tid_in    = req_task_id;
         now_in    = req_tick_now;
         why_in    = req_reason;
         dur_in    = req_sleep_ticks;
         chk_ok_in = (req_check_code == req_current_check);
      end
   end

   always_comb begin
      slot_valid_in    = slot_valid_ff;
      slot_task_in     = slot_task_ff;
      slot_sleeping_in = slot_sleeping_ff;
      slot_waiting_in  = slot_waiting_ff;
      slot_word_in     = slot_word_ff;
      slot_start_in    = slot_start_ff;
      rotate_in        = rotate_ff;
      running_slot_in  = running_slot_ff;
      running_task_in  = running_task_ff;
      probe_in         = probe_ff;
      cnt_in           = cnt_ff;
      res_chosen_in    = res_chosen_ff;
      res_idle_in      = res_idle_ff;
      res_status_in    = res_status_ff;
      res_resched_in   = res_resched_ff;

      if (cmd.capture) begin
         probe_in = next_slot(rotate_ff);
         cnt_in   = '0;
      end

      if (cmd.scan_step) begin
         if (slot_valid_ff[probe_ff] && woke) begin
            slot_sleeping_in[probe_ff] = 1'b0;
         end
         res_status_in  = STS_OK;
         res_resched_in = 1'b0;
         if (runnable) begin
            rotate_in       = probe_ff;
            running_slot_in = probe_ff;
            running_task_in = 1'b1;
            res_chosen_in   = slot_task_ff[probe_ff];
            res_idle_in     = 1'b0;
         end else if (last) begin
            running_task_in = 1'b0;
            res_chosen_in   = idle_task_id;
            res_idle_in     = 1'b1;
         end else begin
            probe_in = next_slot(probe_ff);
            cnt_in   = cnt_ff + 1'b1;
         end
      end

      if (cmd.exec) begin
         res_chosen_in  = '0;
         res_idle_in    = 1'b0;
         res_status_in  = STS_OK;
         res_resched_in = 1'b0;
         case (cmd_ff)
            CMD_ADD: begin
               if (free_hit) begin
                  slot_valid_in[free_idx]    = 1'b1;
                  slot_task_in[free_idx]     = tid_ff;
                  slot_sleeping_in[free_idx] = 1'b0;
                  slot_waiting_in[free_idx]  = 1'b0;
                  slot_word_in[free_idx]     = '0;
                  slot_start_in[free_idx]    = '0;
               end else begin
                  res_status_in = STS_FULL;
               end
            end
            CMD_EXIT: begin
               for (int k = 0; k < MAX_TASKS; k++) begin
                  if (slot_valid_ff[k] && (slot_task_ff[k] == tid_ff)) begin
                     slot_valid_in[k]    = 1'b0;
                     slot_sleeping_in[k] = 1'b0;
                     slot_waiting_in[k]  = 1'b0;
                     if (running_task_ff && (running_slot_ff == SLOT_W'(k))) begin
                        running_task_in = 1'b0;
                     end
                  end
               end
            end
            CMD_WAIT: begin
               if (!chk_ok_ff) begin
                  res_status_in = STS_MISMATCH;
               end else if (!running_task_ff) begin
                  res_status_in = STS_NO_TASK;
               end else begin
                  slot_waiting_in[running_slot_ff] = 1'b1;
                  slot_word_in[running_slot_ff]    = why_ff;
                  res_resched_in                   = 1'b1;
               end
            end
            CMD_NOTIFY: begin
               for (int k = 0; k < MAX_TASKS; k++) begin
                  if (slot_valid_ff[k] && slot_waiting_ff[k] && (slot_word_ff[k] == why_ff)) begin
                     slot_waiting_in[k] = 1'b0;
                     slot_word_in[k]    = '0;
                  end
               end
            end
            CMD_SLEEP: begin
               if (!running_task_ff) begin
                  res_status_in = STS_NO_TASK;
               end else begin
                  slot_sleeping_in[running_slot_ff] = 1'b1;
                  slot_word_in[running_slot_ff]     = {1'b0, dur_ff};
                  slot_start_in[running_slot_ff]    = now_ff;
               end
            end
            default: begin
               res_status_in = STS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_TASKS; k++) begin
            slot_valid_ff[k]    <= 1'b0;
            slot_sleeping_ff[k] <= 1'b0;
            slot_waiting_ff[k]  <= 1'b0;
         end
         rotate_ff       <= '0;
         running_slot_ff <= '0;
         running_task_ff <= 1'b0;
      end else begin
         slot_valid_ff    <= slot_valid_in;
         slot_sleeping_ff <= slot_sleeping_in;
         slot_waiting_ff  <= slot_waiting_in;
         rotate_ff        <= rotate_in;
         running_slot_ff  <= running_slot_in;
         running_task_ff  <= running_task_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      tid_ff         <= tid_in;
      now_ff         <= now_in;
      why_ff         <= why_in;
      dur_ff         <= dur_in;
      chk_ok_ff      <= chk_ok_in;
      slot_task_ff   <= slot_task_in;
      slot_word_ff   <= slot_word_in;
      slot_start_ff  <= slot_start_in;
      probe_ff       <= probe_in;
      cnt_ff         <= cnt_in;
      res_chosen_ff  <= res_chosen_in;
      res_idle_ff    <= res_idle_in;
      res_status_ff  <= res_status_in;
      res_resched_ff <= res_resched_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_chosen_task_ff        <= res_chosen_ff;
         rsp_chose_idle_ff         <= res_idle_ff;
         rsp_status_ff             <= res_status_ff;
         rsp_reschedule_request_ff <= res_resched_ff;
      end
   end

   assign rsp_chosen_task        = rsp_chosen_task_ff;
   assign rsp_chose_idle         = rsp_chose_idle_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_reschedule_request = rsp_reschedule_request_ff;

   `RRTS_ASSERT_NEXT(a_idle_clears_run, cmd.scan_step && last && !runnable, !running_task_ff, "idle pick left a running task")
   `RRTS_ASSERT_NEXT(a_pick_runs, cmd.scan_step && runnable, running_task_ff && running_slot_ff == $past(probe_ff), "picked slot not running")
   `RRTS_ASSERT_NEXT(a_wait_marks, cmd.exec && cmd_ff == CMD_WAIT && chk_ok_ff && running_task_ff, slot_waiting_ff[$past(running_slot_ff)], "wait flag not set")

endmodule

>>> rtl/core/round_robin_task_scheduler.sv
// ---------------------------------------------------------------------------
// Round robin task scheduler
// Add, exit, wait, notify and sleep pass through capture, table edit and publish.
// Schedule probes k slots, k = 1 to 8, one slot per cycle, then publishes.
// A new request is accepted only in idle, once the last result is published.
// Reset: synchronous; clears slot flags, pointers, idle id register and valids.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_tick_now,
   input  logic [31:0] req_reason,
   input  logic [30:0] req_sleep_ticks,
   input  logic [31:0] req_check_code,
   input  logic [31:0] req_current_check,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_chosen_task,
   output logic        rsp_chose_idle,
   output logic [1:0]  rsp_status,
   output logic        rsp_reschedule_request,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rrts_pkg::*;

   localparam logic REG_IDLE_TASK_ID = 1'b0;

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic [7:0]    idle_task_id_ff, idle_task_id_in;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      idle_task_id_in = idle_task_id_ff;
      if (csr_write && (paddr[2] == REG_IDLE_TASK_ID)) begin
         idle_task_id_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_task_id_ff <= '0;
      end else begin
         idle_task_id_ff <= idle_task_id_in;
      end
   end

   assign prdata = (paddr[2] == REG_IDLE_TASK_ID) ? {24'b0, idle_task_id_ff} : '0;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd_o     (cmd)
   );

   rrts_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .idle_task_id           (idle_task_id_ff),
      .req_command            (req_command),
      .req_task_id            (req_task_id),
      .req_tick_now           (req_tick_now),
      .req_reason             (req_reason),
      .req_sleep_ticks        (req_sleep_ticks),
      .req_check_code         (req_check_code),
      .req_current_check      (req_current_check),
      .rsp_chosen_task        (rsp_chosen_task),
      .rsp_chose_idle         (rsp_chose_idle),
      .rsp_status             (rsp_status),
      .rsp_reschedule_request (rsp_reschedule_request)
   );

endmodule

>>> verif/tb_round_robin_task_scheduler.sv
// ---------------------------------------------------------------------------
// Round robin task scheduler testbench
// Drives scheduler commands through the request channel and predicts every
// response with a cycle-free model of the task table, rotate pointer and
// running task. Responses are compared in order. Runs directed corner cases,
// then shaped random traffic across several idle task id settings, with
// random gaps on both channels, a long response hold-off and a sender pause.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
   import rrts_pkg::*;

   localparam logic [2:0]  CMD_RSVD_6        = 3'd6;
   localparam logic [2:0]  CMD_RSVD_7        = 3'd7;
   localparam logic [2:0]  ADDR_IDLE_TASK_ID = 3'd0;
   localparam int unsigned CYCLE_LIMIT       = 800000;
   localparam int unsigned MAX_REPORTS       = 10;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  task_id;
      logic [31:0] tick_now;
      logic [31:0] reason;
      logic [30:0] sleep_ticks;
      logic [31:0] check_code;
      logic [31:0] current_check;
   } sched_request_type;

   typedef struct packed {
      logic [7:0] chosen_task;
      logic       chose_idle;
      logic [1:0] status;
      logic       reschedule_request;
   } sched_outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_command;
   logic [7:0]  req_task_id;
   logic [31:0] req_tick_now;
   logic [31:0] req_reason;
   logic [30:0] req_sleep_ticks;
   logic [31:0] req_check_code;
   logic [31:0] req_current_check;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_chosen_task;
   logic        rsp_chose_idle;
   logic [1:0]  rsp_status;
   logic        rsp_reschedule_request;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // task table mirror
   logic        tbl_valid    [MAX_TASKS] = '{default: 1'b0};
   logic [7:0]  tbl_task     [MAX_TASKS] = '{default: 8'd0};
   logic        tbl_sleeping [MAX_TASKS] = '{default: 1'b0};
   logic        tbl_waiting  [MAX_TASKS] = '{default: 1'b0};
   logic [31:0] tbl_word     [MAX_TASKS] = '{default: 32'd0};
   logic [31:0] tbl_start    [MAX_TASKS] = '{default: 32'd0};
   int          rr_ptr      = 0;
   int          run_slot    = 0;
   bit          run_is_task = 1'b0;
   logic [7:0]  idle_id     = 8'd0;

   sched_outcome_type due_outcomes[$];
   int unsigned    error_count     = 0;
   int unsigned    cycle_count     = 0;
   int unsigned    rsp_hold_cycles = 0;
   bit             no_idle         = 1'b0;
   logic [31:0]    tick_clock;
   logic [31:0]    reason_pool [4];

   round_robin_task_scheduler u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_task_id            (req_task_id),
      .req_tick_now           (req_tick_now),
      .req_reason             (req_reason),
      .req_sleep_ticks        (req_sleep_ticks),
      .req_check_code         (req_check_code),
      .req_current_check      (req_current_check),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_chosen_task        (rsp_chosen_task),
      .rsp_chose_idle         (rsp_chose_idle),
      .rsp_status             (rsp_status),
      .rsp_reschedule_request (rsp_reschedule_request),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_round_robin_task_scheduler: done, errors");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sched_outcome_type compute_outcome(input sched_request_type rq);
      sched_outcome_type o;
      int             p;
      bit             found;
      logic [31:0]    left;
      o = '0;
      case (rq.command)
         CMD_SCHEDULE: begin
            found = 1'b0;
            p = rr_ptr;
            for (int k = 0; k < MAX_TASKS && !found; k++) begin
               p = (p + 1) % MAX_TASKS;
               if (!tbl_valid[p]) continue;
               if (tbl_sleeping[p]) begin
                  left = tbl_word[p] - (rq.tick_now - tbl_start[p]);
                  if (left == 32'd0 || left[31]) tbl_sleeping[p] = 1'b0;
                  else continue;
               end
               if (tbl_waiting[p]) continue;
               found = 1'b1;
            end
            rr_ptr = p;
            if (found) begin
               o.chosen_task = tbl_task[p];
               run_slot = p;
               run_is_task = 1'b1;
            end else begin
               o.chosen_task = idle_id;
               o.chose_idle = 1'b1;
               run_is_task = 1'b0;
            end
         end
         CMD_ADD: begin
            found = 1'b0;
            for (int k = 0; k < MAX_TASKS && !found; k++) begin
               if (!tbl_valid[k]) begin
                  tbl_valid[k] = 1'b1;
                  tbl_task[k] = rq.task_id;
                  tbl_sleeping[k] = 1'b0;
                  tbl_waiting[k] = 1'b0;
                  tbl_word[k] = 32'd0;
                  tbl_start[k] = 32'd0;
                  found = 1'b1;
               end
            end
            if (!found) o.status = STS_FULL;
         end
         CMD_EXIT: begin
            for (int k = 0; k < MAX_TASKS; k++) begin
               if (tbl_valid[k] && tbl_task[k] == rq.task_id) begin
                  tbl_valid[k] = 1'b0;
                  tbl_sleeping[k] = 1'b0;
                  tbl_waiting[k] = 1'b0;
                  if (run_is_task && run_slot == k) run_is_task = 1'b0;
               end
            end
         end
         CMD_WAIT: begin
            if (rq.check_code != rq.current_check) begin
               o.status = STS_MISMATCH;
            end else if (!run_is_task) begin
               o.status = STS_NO_TASK;
            end else begin
               tbl_waiting[run_slot] = 1'b1;
               tbl_word[run_slot] = rq.reason;
               o.reschedule_request = 1'b1;
            end
         end
         CMD_NOTIFY: begin
            for (int k = 0; k < MAX_TASKS; k++) begin
               if (tbl_valid[k] && tbl_waiting[k] && tbl_word[k] == rq.reason) begin
                  tbl_waiting[k] = 1'b0;
                  tbl_word[k] = 32'd0;
               end
            end
         end
         CMD_SLEEP: begin
            if (!run_is_task) begin
               o.status = STS_NO_TASK;
            end else begin
               tbl_sleeping[run_slot] = 1'b1;
               tbl_word[run_slot] = {1'b0, rq.sleep_ticks};
               tbl_start[run_slot] = rq.tick_now;
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic sched_request_type random_request(input logic [2:0] cmd);
      sched_request_type rq;
      rq.command       = cmd;
      rq.task_id       = 8'($urandom);
      rq.tick_now      = $urandom;
      rq.reason        = $urandom;
      rq.sleep_ticks   = 31'($urandom);
      rq.check_code    = $urandom;
      rq.current_check = $urandom;
      return rq;
   endfunction

   task automatic send_request(input sched_request_type rq);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= rq.command;
      req_task_id       <= rq.task_id;
      req_tick_now      <= rq.tick_now;
      req_reason        <= rq.reason;
      req_sleep_ticks   <= rq.sleep_ticks;
      req_check_code    <= rq.check_code;
      req_current_check <= rq.current_check;
      do @(posedge clock); while (!req_ready);
      due_outcomes.push_back(compute_outcome(rq));
   endtask

   task automatic issue(input logic [2:0] cmd, input logic [7:0] tid,
                        input logic [31:0] tick, input logic [31:0] why,
                        input logic [30:0] dur, input bit codes_match);
      sched_request_type rq;
      rq = random_request(cmd);
      rq.task_id     = tid;
      rq.tick_now    = tick;
      rq.reason      = why;
      rq.sleep_ticks = dur;
      if (codes_match) rq.current_check = rq.check_code;
      else rq.current_check = ~rq.check_code;
      send_request(rq);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_outcomes.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_idle_task_id(input logic [7:0] value);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_IDLE_TASK_ID;
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      idle_id = value;
   endtask

   task automatic test_directed_cases();
      logic [31:0] t;
      t = 32'hFFFF_FFFC;
      issue(CMD_SCHEDULE, 8'h00, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_WAIT, 8'h00, t, 32'h1234_5678, 31'd0, 1'b1);
      issue(CMD_WAIT, 8'h00, t, 32'h1234_5678, 31'd0, 1'b0);
      issue(CMD_SLEEP, 8'h00, t, 32'd0, 31'd3, 1'b1);
      issue(CMD_NOTIFY, 8'h00, t, 32'hFFFF_FFFF, 31'd0, 1'b1);
      issue(CMD_EXIT, 8'h00, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h00, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'hFF, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h5A, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h03, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h03, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h07, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h80, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h01, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_ADD, 8'h11, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_SCHEDULE, 8'h00, t, 32'd0, 31'd0, 1'b1);
      // sleep across the tick wrap, then probe one tick early and exactly on time
      issue(CMD_SLEEP, 8'h00, t, 32'd0, 31'd5, 1'b1);
      issue(CMD_SCHEDULE, 8'h00, t + 32'd1, 32'd0, 31'd0, 1'b1);
      issue(CMD_WAIT, 8'h00, t + 32'd1, 32'hDEAD_BEEF, 31'd0, 1'b1);
      for (int i = 0; i < 7; i++)
         issue(CMD_SCHEDULE, 8'h00, t + 32'd4, 32'd0, 31'd0, 1'b1);
      issue(CMD_NOTIFY, 8'h00, t, 32'hDEAD_BEEF, 31'd0, 1'b1);
      issue(CMD_EXIT, 8'h03, t, 32'd0, 31'd0, 1'b1);
      issue(CMD_SCHEDULE, 8'h00, t + 32'd5, 32'd0, 31'd0, 1'b1);
      issue(CMD_SLEEP, 8'h00, t + 32'd5, 32'd0, 31'h7FFF_FFFF, 1'b1);
      issue(CMD_RSVD_6, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      issue(CMD_RSVD_7, 8'h00, 32'd0, 32'd0, 31'd0, 1'b0);
      issue(CMD_SCHEDULE, 8'h00, t + 32'd9, 32'd0, 31'd0, 1'b1);
   endtask

   task automatic test_random_traffic(input int unsigned count);
      sched_request_type rq;
      logic [2:0]     cmd;
      int unsigned    r;
      int unsigned    done;
      done = 0;
      for (int i = 0; i < 4; i++) reason_pool[i] = $urandom;
      while (done < count) begin
         r = $urandom_range(0, 99);
         if (r < 34) cmd = CMD_SCHEDULE;
         else if (r < 46) cmd = CMD_ADD;
         else if (r < 53) cmd = CMD_EXIT;
         else if (r < 65) cmd = CMD_WAIT;
         else if (r < 77) cmd = CMD_NOTIFY;
         else if (r < 97) cmd = CMD_SLEEP;
         else if (r < 98) cmd = CMD_RSVD_6;
         else cmd = CMD_RSVD_7;
         rq = random_request(cmd);
         if ($urandom_range(0, 99) < 2) tick_clock += $urandom;
         else tick_clock += 32'($urandom_range(0, 12));
         if (cmd == CMD_SCHEDULE || cmd == CMD_SLEEP) rq.tick_now = tick_clock;
         r = $urandom_range(0, 99);
         if (r < 80) rq.task_id = 8'($urandom_range(0, 5));
         else if (r < 90) rq.task_id = 8'hFF;
         if ($urandom_range(0, 99) < 80) rq.reason = reason_pool[$urandom_range(0, 3)];
         if ($urandom_range(0, 99) < 85) rq.current_check = rq.check_code;
         r = $urandom_range(0, 99);
         if (r < 80) rq.sleep_ticks = 31'($urandom_range(0, 60));
         else if (r < 95) rq.sleep_ticks = 31'($urandom_range(0, 400));
         send_request(rq);
         if (cmd != CMD_RSVD_6 && cmd != CMD_RSVD_7) done++;
      end
   endtask

   task automatic test_idle_task_id_config(input logic [7:0] value, input int unsigned count);
      write_idle_task_id(value);
      test_random_traffic(count);
   endtask

   task automatic test_output_backpressure();
      rsp_hold_cycles = 300;
      no_idle = 1'b1;
      test_random_traffic(16);
      no_idle = 1'b0;
   endtask

   task automatic test_back_to_back(input int unsigned count);
      no_idle = 1'b1;
      test_random_traffic(count);
      no_idle = 1'b0;
   endtask

   task automatic test_sender_pause(input int unsigned count);
      wait_drained();
      repeat ($urandom_range(30, 80)) @(posedge clock);
      test_random_traffic(count);
   endtask

   // response side: random stalls, plus the requested long hold-off
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            stall = pick_gap();
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      sched_outcome_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected transaction: chosen=%0d idle=%0d status=%0d resched=%0d",
                        rsp_chosen_task, rsp_chose_idle, rsp_status,
                        rsp_reschedule_request);
         end else begin
            exp = due_outcomes.pop_front();
            if (rsp_chosen_task !== exp.chosen_task || rsp_chose_idle !== exp.chose_idle ||
                rsp_status !== exp.status ||
                rsp_reschedule_request !== exp.reschedule_request) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           exp.chosen_task, exp.chose_idle, exp.status,
                           exp.reschedule_request, rsp_chosen_task, rsp_chose_idle,
                           rsp_status, rsp_reschedule_request);
            end
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_command       <= CMD_SCHEDULE;
      req_task_id       <= 8'd0;
      req_tick_now      <= 32'd0;
      req_reason        <= 32'd0;
      req_sleep_ticks   <= 31'd0;
      req_check_code    <= 32'd0;
      req_current_check <= 32'd0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= ADDR_IDLE_TASK_ID;
      pwdata            <= 32'd0;
      tick_clock = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_idle_task_id_config(8'hFF, 500);
      test_output_backpressure();
      write_idle_task_id(8'($urandom));
      test_back_to_back(300);
      test_sender_pause(100);
      tick_clock = 32'hFFFF_FF00;
      test_idle_task_id_config(8'h00, 500);
      test_idle_task_id_config(8'($urandom), 400);

      wait_drained();
      repeat (12) @(posedge clock);
      if (error_count == 0 && due_outcomes.size() == 0) begin
         $display("tb_round_robin_task_scheduler: done, clean");
      end else begin
         $display("tb_round_robin_task_scheduler: done, errors");
      end
      $finish;
   end

endmodule

>>> round_robin_task_scheduler.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_ctrl.sv
rtl/core/rrts_dp.sv
rtl/core/round_robin_task_scheduler.sv
verif/tb_round_robin_task_scheduler.sv
